FILE: design/mmwd_pkg.sv
package mmwd_pkg;

   localparam int unsigned DEF_SAMPLE_WIDTH = 16;
   localparam int unsigned DEF_TIME_WIDTH   = 32;
   localparam int unsigned DEF_FACTOR_WIDTH = 16;

   localparam int unsigned CSR_INDEX_WIDTH  = 8;

   // result queue, one entry per window or bypassed sample
   localparam int unsigned QUEUE_DEPTH      = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DECIMATION_FACTOR = 8'd0,
      REG_BYPASS            = 8'd1
   } csr_reg_type;

   // push into the result queue; pair set means max then min
   typedef struct packed {
      logic push;
      logic pair;
   } entry_ctl_type;

endpackage

FILE: design/min_max_window_decimator.sv
// Min/max window decimator for one channel of signed converter samples. Each req word carries
// a sample, its timestamp and an end-of-channel mark in tlast. Samples are gathered into windows
// of decimation_factor samples (0 acts as 1); when a window fills, or on end of channel, two rsp
// words follow: the maximum (tuser 0, tlast 0) then the minimum (tuser 1, tlast 1), both stamped
// with the window's first timestamp. With bypass set each sample goes out once, unchanged, with
// tuser 0 and tlast 1, and any open window is dropped. A sample passes an input register and is
// folded into the running extremes on its way into a two-entry result queue; one sample can be
// taken every clock while the queue has room; the rsp side sets intake when windows close faster
// than every second sample. The user must write configuration only while idle; the block does
// not enforce it. csr_ready is always high and unknown register indexes are ignored.
module min_max_window_decimator
   import mmwd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int unsigned TIME_WIDTH   = DEF_TIME_WIDTH,
   parameter int unsigned FACTOR_WIDTH = DEF_FACTOR_WIDTH,
   localparam int unsigned DATA_WIDTH  = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [DATA_WIDTH-1:0]      req_tdata,   // sample, timestamp
   input  logic                       req_tlast,

   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [DATA_WIDTH-1:0]      rsp_tdata,   // value, window_time
   output logic                       rsp_tuser,   // is_minimum
   output logic                       rsp_tlast,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [FACTOR_WIDTH-1:0]    csr_data
);

   logic [FACTOR_WIDTH-1:0]        factor_ff;
   logic                           bypass_ff;

   logic                           held_valid;
   logic signed [SAMPLE_WIDTH-1:0] held_sample;
   logic        [TIME_WIDTH-1:0]   held_timestamp;
   logic                           held_eoc;
   logic                           can_push;
   logic                           advance;

   entry_ctl_type                  ctl;
   logic signed [SAMPLE_WIDTH-1:0] first_value;
   logic signed [SAMPLE_WIDTH-1:0] second_value;
   logic        [TIME_WIDTH-1:0]   entry_time;

   logic signed [SAMPLE_WIDTH-1:0] out_value;
   logic        [TIME_WIDTH-1:0]   out_window_time;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_WIDTH'(1);
         bypass_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_DECIMATION_FACTOR: begin
               factor_ff <= csr_data;
            end
            REG_BYPASS: begin
               bypass_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = held_valid && can_push;

   mmwd_ingress #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_ingress (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (req_tvalid),
      .in_ready            (req_tready),
      .in_sample           (req_tdata[SAMPLE_WIDTH-1:0]),
      .in_timestamp        (req_tdata[SAMPLE_WIDTH +: TIME_WIDTH]),
      .in_end_of_channel   (req_tlast),
      .take                (can_push),
      .held_valid          (held_valid),
      .held_sample         (held_sample),
      .held_timestamp      (held_timestamp),
      .held_end_of_channel (held_eoc)
   );

   mmwd_window #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TIME_WIDTH   (TIME_WIDTH),
      .FACTOR_WIDTH (FACTOR_WIDTH)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .sample         (held_sample),
      .timestamp      (held_timestamp),
      .end_of_channel (held_eoc),
      .factor         (factor_ff),
      .bypass         (bypass_ff),
      .ctl            (ctl),
      .first_value    (first_value),
      .second_value   (second_value),
      .entry_time     (entry_time)
   );

   mmwd_rsp_queue #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .can_push        (can_push),
      .ctl             (ctl),
      .first_value     (first_value),
      .second_value    (second_value),
      .entry_time      (entry_time),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_value       (out_value),
      .out_window_time (out_window_time),
      .out_is_minimum  (rsp_tuser),
      .out_last        (rsp_tlast)
   );

   assign rsp_tdata = DATA_WIDTH'({out_window_time, out_value});

endmodule

FILE: design/mmwd_ingress.sv
module mmwd_ingress
   import mmwd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int unsigned TIME_WIDTH   = DEF_TIME_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic        [TIME_WIDTH-1:0]   in_timestamp,
   input  logic                           in_end_of_channel,
   input  logic                           take,
   output logic                           held_valid,
   output logic signed [SAMPLE_WIDTH-1:0] held_sample,
   output logic        [TIME_WIDTH-1:0]   held_timestamp,
   output logic                           held_end_of_channel
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic        [TIME_WIDTH-1:0]   timestamp_ff;
   logic                           eoc_ff;

   assign in_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sample_ff    <= in_sample;
         timestamp_ff <= in_timestamp;
         eoc_ff       <= in_end_of_channel;
      end
   end

   assign held_valid          = valid_ff;
   assign held_sample         = sample_ff;
   assign held_timestamp      = timestamp_ff;
   assign held_end_of_channel = eoc_ff;

endmodule

FILE: design/mmwd_window.sv
module mmwd_window
   import mmwd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int unsigned TIME_WIDTH   = DEF_TIME_WIDTH,
   parameter int unsigned FACTOR_WIDTH = DEF_FACTOR_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic        [TIME_WIDTH-1:0]   timestamp,
   input  logic                           end_of_channel,
   input  logic        [FACTOR_WIDTH-1:0] factor,
   input  logic                           bypass,
   output entry_ctl_type                  ctl,
   output logic signed [SAMPLE_WIDTH-1:0] first_value,
   output logic signed [SAMPLE_WIDTH-1:0] second_value,
   output logic        [TIME_WIDTH-1:0]   entry_time
);

   logic        [FACTOR_WIDTH-1:0] pos_ff, pos_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in;
   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic        [TIME_WIDTH-1:0]   start_ff, start_in;
   logic        [FACTOR_WIDTH-1:0] factor_eff;
   logic        [FACTOR_WIDTH:0]   count;
   logic                           close;

   // running extremes and window start
   always_comb begin
      factor_eff = (factor == '0) ? FACTOR_WIDTH'(1) : factor;
      count      = {1'b0, pos_ff} + (FACTOR_WIDTH + 1)'(1);
      close      = end_of_channel || (count >= {1'b0, factor_eff});
      if (pos_ff == '0) begin
         max_in   = sample;
         min_in   = sample;
         start_in = timestamp;
      end else begin
         max_in   = (sample > max_ff) ? sample : max_ff;
         min_in   = (sample < min_ff) ? sample : min_ff;
         start_in = start_ff;
      end
   end

   // window position and queue push
   always_comb begin
      ctl = '0;
      if (bypass) begin
         pos_in   = '0;
         ctl.push = advance;
         ctl.pair = 1'b0;
      end else begin
         pos_in   = close ? '0 : count[FACTOR_WIDTH-1:0];
         ctl.push = advance && close;
         ctl.pair = 1'b1;
      end
   end

   assign first_value  = bypass ? sample : max_in;
   assign second_value = min_in;
   assign entry_time   = bypass ? timestamp : start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         max_ff   <= max_in;
         min_ff   <= min_in;
         start_ff <= start_in;
      end
   end

endmodule

FILE: design/mmwd_rsp_queue.sv
module mmwd_rsp_queue
   import mmwd_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int unsigned TIME_WIDTH   = DEF_TIME_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           can_push,
   input  entry_ctl_type                  ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] first_value,
   input  logic signed [SAMPLE_WIDTH-1:0] second_value,
   input  logic        [TIME_WIDTH-1:0]   entry_time,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_value,
   output logic        [TIME_WIDTH-1:0]   out_window_time,
   output logic                           out_is_minimum,
   output logic                           out_last
);

   localparam int unsigned PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic signed [SAMPLE_WIDTH-1:0] first_ff  [QUEUE_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] second_ff [QUEUE_DEPTH];
   logic        [TIME_WIDTH-1:0]   time_ff   [QUEUE_DEPTH];
   logic                           pair_ff   [QUEUE_DEPTH];

   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   phase_ff, phase_in;
   logic                   head_pair;
   logic                   fire;
   logic                   pop;
   logic                   push;

   assign can_push  = (count_ff != COUNT_WIDTH'(QUEUE_DEPTH));
   assign push      = ctl.push && can_push;
   assign out_valid = (count_ff != '0);
   assign head_pair = pair_ff[rd_ptr_ff];
   assign fire      = out_valid && out_ready;
   assign pop       = fire && (!head_pair || phase_ff);

   // a pair entry goes out as two words: maximum, then minimum
   assign out_value       = (head_pair && phase_ff) ? second_ff[rd_ptr_ff]
                                                    : first_ff[rd_ptr_ff];
   assign out_window_time = time_ff[rd_ptr_ff];
   assign out_is_minimum  = head_pair && phase_ff;
   assign out_last        = !head_pair || phase_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (fire) begin
         phase_in = head_pair && !phase_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         first_ff[wr_ptr_ff]  <= first_value;
         second_ff[wr_ptr_ff] <= second_value;
         time_ff[wr_ptr_ff]   <= entry_time;
         pair_ff[wr_ptr_ff]   <= ctl.pair;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_phase_needs_entry: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (out_valid && head_pair))
      else $error("second half of a pair with no pair entry at the head");

   a_min_follows_max: assert property (@(posedge clock) disable iff (reset)
      (fire && head_pair && !phase_ff) |=> (out_valid && out_is_minimum && out_last))
      else $error("maximum word not followed by minimum word");
`endif

endmodule
